@@ design/vgdf_pkg.sv @@
package vgdf_pkg;

    // voxel index and key layout
    localparam int AXIS_W = 21;
    localparam int KEY_W  = 3 * AXIS_W;

    localparam logic signed [31:0] AXIS_MAX = 32'sd1048575;
    localparam logic signed [31:0] AXIS_MIN = -32'sd1048576;

    // multiplicative hash constant, split in 32-bit halves
    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;
    localparam logic [31:0] HASH_LO  = HASH_MUL[31:0];
    localparam logic [31:0] HASH_HI  = HASH_MUL[63:32];

    // reciprocal voxel size after reset (10.0 in Q16.16)
    localparam logic [31:0] INV_RESET = 32'd655360;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_point;

    typedef logic [KEY_W-1:0] t_key;

    // floor of a signed Q32.32 product, saturated to a 21-bit voxel index
    function automatic logic [AXIS_W-1:0] axis_index(input logic [63:0] prod);
        logic signed [31:0] fl;
        fl = $signed(prod[63:32]);
        if (fl > AXIS_MAX) begin
            axis_index = AXIS_MAX[AXIS_W-1:0];
        end else if (fl < AXIS_MIN) begin
            axis_index = AXIS_MIN[AXIS_W-1:0];
        end else begin
            axis_index = fl[AXIS_W-1:0];
        end
    endfunction

endpackage

@@ design/vgdf_front.sv @@
module vgdf_front #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [31:0]                    i_cfg_wdata,
    input  logic                           i_push,
    output logic                           o_full,
    input  vgdf_pkg::t_point               i_pt,
    output logic                           o_valid,
    input  logic                           i_q_full,
    output vgdf_pkg::t_point               o_pt,
    output vgdf_pkg::t_key                 o_key,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_home
);
    import vgdf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $clog2(3 * TABLE_DEPTH);
    localparam logic [31:0]   RECIP_M = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));
    localparam logic [31:0]   DEPTH_C = 32'(TABLE_DEPTH);
    localparam logic [RW-1:0] DEPTH_R = RW'(TABLE_DEPTH);

    logic [31:0]   r_inv;
    logic [8:1]    r_v;
    t_point        r_pt [1:8];
    t_key          r_key [3:8];
    logic [63:0]   r_px, r_py, r_pz;
    logic [31:0]   r_t0, r_t1, r_t2;
    logic [31:0]   r_h [5:7];
    logic [31:0]   r_qest;
    logic [31:0]   r_qd;
    logic [RW-1:0] r_r0;

    logic               adv;
    logic signed [32:0] inv_s;
    logic signed [64:0] n_mx, n_my, n_mz;
    t_key               n_key;
    logic [63:0]        n_m0;
    logic [31:0]        n_t1, n_t2, n_h;
    logic [63:0]        n_qm;
    logic [31:0]        n_qd, n_diff;
    logic [RW-1:0]      n_r1, n_r2;

    // whole pipeline moves unless its last item cannot enter the queue
    assign adv     = !r_v[8] || !i_q_full;
    assign o_full  = !adv;
    assign o_valid = r_v[8];

    // reciprocal voxel size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
        end else if (i_cfg_wen) begin
            r_inv <= i_cfg_wdata;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[7:1], i_push};
        end
    end

    // coordinate times reciprocal, one multiplier per axis
    assign inv_s = $signed({1'b0, r_inv});
    assign n_mx  = r_pt[1].x * inv_s;
    assign n_my  = r_pt[1].y * inv_s;
    assign n_mz  = r_pt[1].z * inv_s;

    // floor, saturate and pack the key
    assign n_key = {axis_index(r_px), axis_index(r_py), axis_index(r_pz)};

    // hash partial products: bits 63..32 of key times the hash constant
    assign n_m0 = {32'd0, r_key[3][31:0]} * {32'd0, HASH_LO};
    assign n_t1 = 32'(r_key[3][31:0] * HASH_HI);
    assign n_t2 = 32'({1'b0, r_key[3][KEY_W-1:32]} * HASH_LO);
    assign n_h  = r_t0 + r_t1 + r_t2;

    // modulo table depth: reciprocal quotient estimate, then correction
    assign n_qm   = {32'd0, r_h[5]} * {32'd0, RECIP_M};
    assign n_qd   = 32'(r_qest * DEPTH_C);
    assign n_diff = r_h[7] - r_qd;
    assign n_r1   = (r_r0 >= DEPTH_R) ? r_r0 - DEPTH_R : r_r0;
    assign n_r2   = (n_r1 >= DEPTH_R) ? n_r1 - DEPTH_R : n_r1;

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pt[1] <= i_pt;
            for (int s = 2; s <= 8; s++) begin
                r_pt[s] <= r_pt[s-1];
            end
            r_px     <= n_mx[63:0];
            r_py     <= n_my[63:0];
            r_pz     <= n_mz[63:0];
            r_key[3] <= n_key;
            for (int s = 4; s <= 8; s++) begin
                r_key[s] <= r_key[s-1];
            end
            r_t0   <= n_m0[63:32];
            r_t1   <= n_t1;
            r_t2   <= n_t2;
            r_h[5] <= n_h;
            r_h[6] <= r_h[5];
            r_h[7] <= r_h[6];
            r_qest <= n_qm[63:32];
            r_qd   <= n_qd;
            r_r0   <= n_diff[RW-1:0];
        end
    end

    assign o_pt   = r_pt[8];
    assign o_key  = r_key[8];
    assign o_home = n_r2[AW-1:0];

endmodule

@@ design/vgdf_queue.sv @@
module vgdf_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    logic          do_push, do_pop;
    logic [PW-1:0] n_wp, n_rp;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wp    = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
    assign n_rp    = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ design/vgdf_back.sv @@
module vgdf_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PROBES  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  vgdf_pkg::t_point               i_pt,
    input  vgdf_pkg::t_key                 i_key,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_home,
    input  logic                           i_pop,
    output logic                           o_empty,
    output vgdf_pkg::t_point               o_pt,
    output logic                           o_overflow
);
    import vgdf_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int UW    = $clog2(TABLE_DEPTH + 1);
    localparam int LIMIT = (MAX_PROBES < TABLE_DEPTH) ? MAX_PROBES : TABLE_DEPTH;
    localparam int CW    = $clog2(LIMIT + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    // slot memory: valid bit over key; list of slots filled this frame
    logic [KEY_W:0] r_slot_mem [TABLE_DEPTH];
    logic [AW-1:0]  r_list_mem [TABLE_DEPTH];
    logic [KEY_W:0] r_slot_rd;
    logic [AW-1:0]  r_list_rd;

    logic [2:0]    r_state, n_state;
    t_key          r_key;
    t_point        r_pt;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_cnt;
    logic [UW-1:0] r_used;
    logic [UW-1:0] r_walk;
    logic          r_clr_v;
    logic          r_ovf;
    logic          r_out_v;
    t_point        r_out_pt;
    logic          r_out_ovf;

    logic           hit, free, last_probe, walk_more, out_free, load, list_we;
    logic [AW-1:0]  n_slot_inc, rd_addr;
    logic           slot_we;
    logic [AW-1:0]  slot_waddr;
    logic [KEY_W:0] slot_wdata;

    assign hit        = r_slot_rd[KEY_W] && (r_slot_rd[KEY_W-1:0] == r_key);
    assign free       = !r_slot_rd[KEY_W];
    assign last_probe = (r_cnt == CW'(LIMIT-1));
    assign walk_more  = (r_walk != r_used);
    assign out_free   = !r_out_v || i_pop;
    assign load       = (r_state == ST_EMIT) && out_free;
    assign n_slot_inc = (r_slot == AW'(TABLE_DEPTH-1)) ? '0 : r_slot + 1'b1;
    assign rd_addr    = (r_state == ST_IDLE) ? i_home : n_slot_inc;
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign list_we    = (r_state == ST_PROBE) && free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_walk == UW'(TABLE_DEPTH-1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (!i_q_empty) n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (hit) begin
                    n_state = r_pt.last ? ST_CLEAR : ST_IDLE;
                end else if (free || last_probe) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) n_state = r_pt.last ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR: begin
                if (!walk_more && !r_clr_v) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // slot memory write port: sweep, insert or frame clear
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '0;
        unique case (r_state)
            ST_INIT: begin
                slot_we    = 1'b1;
                slot_waddr = r_walk[AW-1:0];
            end
            ST_PROBE: begin
                slot_we    = free;
                slot_wdata = {1'b1, r_key};
            end
            ST_CLEAR: begin
                slot_we    = r_clr_v;
                slot_waddr = r_list_rd;
            end
            default: begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= r_slot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_list_mem[r_used[AW-1:0]] <= r_slot;
        end
        r_list_rd <= r_list_mem[r_walk[AW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_walk  <= '0;
            r_used  <= '0;
            r_clr_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_v <= (r_state == ST_CLEAR) && walk_more;
            if (r_state == ST_INIT || (r_state == ST_CLEAR && walk_more)) begin
                r_walk <= r_walk + 1'b1;
            end else if (r_state != ST_CLEAR) begin
                r_walk <= '0;
            end
            if (list_we) begin
                r_used <= r_used + 1'b1;
            end else if (r_state == ST_CLEAR && n_state == ST_IDLE) begin
                r_used <= '0;
            end
            if (load) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // item under probe and result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_key  <= i_key;
            r_pt   <= i_pt;
            r_slot <= i_home;
            r_cnt  <= '0;
        end else if (r_state == ST_PROBE) begin
            r_slot <= n_slot_inc;
            r_cnt  <= r_cnt + 1'b1;
            r_ovf  <= !free;
        end
        if (load) begin
            r_out_pt  <= r_pt;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_empty    = !r_out_v;
    assign o_pt       = r_out_pt;
    assign o_overflow = r_out_ovf;

endmodule

@@ design/voxel_grid_dedup_filter_core.sv @@
// front hash pipeline is 8 stages and takes one item per cycle into a 4-entry queue,
// except while its last stage holds an item and that queue is full
// the probe engine works on one item at a time through its single slot-memory read port;
// a kept item also passes an emit state, and a last item adds a clear of the slots used
// reset is synchronous; afterwards the slot memory is swept over all TABLE_DEPTH slots before
// the first item is probed (items are still queued meanwhile)
module voxel_grid_dedup_filter_core #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PROBES  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_last_point,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] o_kept_x,
    output logic signed [31:0] o_kept_y,
    output logic signed [31:0] o_kept_z,
    output logic               o_table_overflow,
    output logic               o_frame_end
);
    import vgdf_pkg::*;

    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int PW          = $bits(t_point);
    localparam int QW          = PW + KEY_W + AW;
    localparam int QUEUE_DEPTH = 4;

    t_point        in_pt, f_pt, b_pt, out_pt;
    t_key          f_key, b_key;
    logic [AW-1:0] f_home, b_home;
    logic          f_valid, q_full, q_empty, q_pop;
    logic [QW-1:0] q_wdata, q_rdata;

    // input item
    assign in_pt.x    = i_point_x;
    assign in_pt.y    = i_point_y;
    assign in_pt.z    = i_point_z;
    assign in_pt.last = i_last_point;

    // key and home slot computation
    vgdf_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_pt        (in_pt),
        .o_valid     (f_valid),
        .i_q_full    (q_full),
        .o_pt        (f_pt),
        .o_key       (f_key),
        .o_home      (f_home)
    );

    // queue between hashing and probing
    assign q_wdata = {f_home, f_key, f_pt};

    vgdf_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign b_pt   = q_rdata[PW-1:0];
    assign b_key  = q_rdata[PW+KEY_W-1:PW];
    assign b_home = q_rdata[QW-1:PW+KEY_W];

    // probe engine and voxel set
    vgdf_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBES  (MAX_PROBES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pt       (b_pt),
        .i_key      (b_key),
        .i_home     (b_home),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_pt       (out_pt),
        .o_overflow (o_table_overflow)
    );

    assign o_kept_x    = out_pt.x;
    assign o_kept_y    = out_pt.y;
    assign o_kept_z    = out_pt.z;
    assign o_frame_end = out_pt.last;

endmodule

@@ test/voxel_grid_dedup_filter_core_tb.sv @@
`timescale 1ns / 100ps

module voxel_grid_dedup_filter_core_tb;

    import vgdf_pkg::*;

    localparam int TABLE_DEPTH  = 4096;
    localparam int MAX_PROBES   = 16;
    localparam int PROBE_WINDOW = (MAX_PROBES < TABLE_DEPTH) ? MAX_PROBES : TABLE_DEPTH;

    // idle cycles allowed after the last result before a register write; covers
    // dropped items still in the pipeline and queue behind the last kept one
    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT   = 20000;

    localparam logic [31:0] INV_ZERO  = 32'd0;
    localparam logic [31:0] INV_MIN   = 32'd1;
    localparam logic [31:0] INV_ONE   = 32'h0001_0000;
    localparam logic [31:0] INV_TENTH = 32'd6554;
    localparam logic [31:0] INV_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STEP_POINT,
        STEP_CONFIG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        t_point      pt;
        logic [31:0] inv;
    } t_stim_step;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               overflow;
        logic               frame_end;
    } t_kept_point;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // dut connections
    logic        cfg_wen   = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    t_point      drive_pt  = '0;
    logic        full;
    logic        empty;
    logic signed [31:0] kept_x;
    logic signed [31:0] kept_y;
    logic signed [31:0] kept_z;
    logic        kept_overflow;
    logic        kept_frame_end;

    voxel_grid_dedup_filter_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBES  (MAX_PROBES)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wen        (cfg_wen),
        .i_cfg_wdata      (cfg_wdata),
        .push             (push),
        .full             (full),
        .i_point_x        (drive_pt.x),
        .i_point_y        (drive_pt.y),
        .i_point_z        (drive_pt.z),
        .i_last_point     (drive_pt.last),
        .pop              (pop),
        .empty            (empty),
        .o_kept_x         (kept_x),
        .o_kept_y         (kept_y),
        .o_kept_z         (kept_z),
        .o_table_overflow (kept_overflow),
        .o_frame_end      (kept_frame_end)
    );

    // voxel set model and bookkeeping
    logic [31:0]   grid_inv = INV_RESET;
    t_key          voxel_slot_key [TABLE_DEPTH];
    bit            voxel_slot_used [TABLE_DEPTH];
    t_kept_point   kept_q[$];
    t_stim_step    stim_q[$];

    int n_due      = 0;
    int n_seen     = 0;
    int n_pushed   = 0;
    int n_dropped  = 0;
    int n_overflow = 0;
    int n_settings = 0;
    int n_errors   = 0;
    int settle_cnt = 0;
    bit all_sent   = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // floor(coord * inv) as a signed Q32.32 product, clamped to a 21-bit index
    function automatic logic [AXIS_W-1:0] grid_axis(input logic signed [31:0] coord,
                                                    input logic [31:0] inv);
        longint prod;
        longint cell_idx;
        prod     = longint'(coord) * longint'({32'd0, inv});
        cell_idx = prod >>> 32;
        if (cell_idx > longint'(AXIS_MAX)) begin
            cell_idx = longint'(AXIS_MAX);
        end else if (cell_idx < longint'(AXIS_MIN)) begin
            cell_idx = longint'(AXIS_MIN);
        end
        return cell_idx[AXIS_W-1:0];
    endfunction

    function automatic t_key voxel_key(input t_point pt, input logic [31:0] inv);
        return {grid_axis(pt.x, inv), grid_axis(pt.y, inv), grid_axis(pt.z, inv)};
    endfunction

    function automatic int unsigned home_slot(input t_key key);
        logic [63:0] mixed;
        mixed = 64'(key) * HASH_MUL;
        return int'((mixed >> 32) % TABLE_DEPTH);
    endfunction

    // probe the voxel set for one accepted point and queue the point if it is kept
    task automatic filter_point(input t_point pt);
        t_key        key;
        int unsigned home;
        int unsigned slot;
        int          i;
        bit          hit;
        bit          placed;
        key    = voxel_key(pt, grid_inv);
        home   = home_slot(key);
        hit    = 1'b0;
        placed = 1'b0;
        for (i = 0; i < PROBE_WINDOW && !hit && !placed; i++) begin
            slot = (home + i) % TABLE_DEPTH;
            if (!voxel_slot_used[slot]) begin
                voxel_slot_key[slot]  = key;
                voxel_slot_used[slot] = 1'b1;
                placed = 1'b1;
            end else if (voxel_slot_key[slot] == key) begin
                hit = 1'b1;
            end
        end
        if (hit) begin
            n_dropped++;
        end else begin
            kept_q.push_back('{x: pt.x, y: pt.y, z: pt.z, overflow: !placed,
                               frame_end: pt.last});
            n_due++;
            if (!placed) n_overflow++;
        end
        if (pt.last) begin
            voxel_slot_used = '{default: 1'b0};
        end
    endtask

    // idle mix changes as the run goes on
    function automatic int unsigned sender_idle_pct();
        if (n_pushed < 380) return 22;
        if (n_pushed < 760) return 54;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (n_pushed < 380) return 54;
        if (n_pushed < 760) return 22;
        return 0;
    endfunction

    // driver: points, register writes and drain pauses from the stimulus queue
    always @(posedge clk) begin : drive
        logic       nxt_push;
        logic       nxt_wen;
        t_stim_step head;
        if (!rst_n) begin
            push    <= 1'b0;
            cfg_wen <= 1'b0;
        end else begin
            nxt_push = push;
            nxt_wen  = 1'b0;
            if (push && !full) begin
                filter_point(drive_pt);
                n_pushed <= n_pushed + 1;
                nxt_push = 1'b0;
            end
            if (!nxt_push && stim_q.size() != 0) begin
                head = stim_q[0];
                unique case (head.kind)
                    STEP_POINT: begin
                        if (!chance(sender_idle_pct())) begin
                            drive_pt <= head.pt;
                            nxt_push = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    STEP_CONFIG: begin
                        nxt_wen = 1'b1;
                        cfg_wdata <= head.inv;
                        grid_inv = head.inv;
                        n_settings++;
                        void'(stim_q.pop_front());
                    end
                    default: begin
                        // hold off until every kept point is back and the block settles
                        if (n_seen == n_due) begin
                            settle_cnt++;
                            if (settle_cnt >= SETTLE_CYCLES) begin
                                settle_cnt = 0;
                                void'(stim_q.pop_front());
                            end
                        end else begin
                            settle_cnt = 0;
                        end
                    end
                endcase
            end
            push     <= nxt_push;
            cfg_wen  <= nxt_wen;
            all_sent <= (stim_q.size() == 0) && !nxt_push;
        end
    end

    // monitor: compare each kept point with the oldest expectation
    always @(posedge clk) begin : collect
        t_kept_point want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_seen <= n_seen + 1;
                if (kept_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected point %h %h %h", kept_x, kept_y,
                                              kept_z));
                end else begin
                    want = kept_q.pop_front();
                    if (kept_x !== want.x)
                        report_mismatch($sformatf("kept_x %h, expected %h", kept_x, want.x));
                    if (kept_y !== want.y)
                        report_mismatch($sformatf("kept_y %h, expected %h", kept_y, want.y));
                    if (kept_z !== want.z)
                        report_mismatch($sformatf("kept_z %h, expected %h", kept_z, want.z));
                    if (kept_overflow !== want.overflow)
                        report_mismatch($sformatf("table_overflow %b, expected %b",
                                                  kept_overflow, want.overflow));
                    if (kept_frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  kept_frame_end, want.frame_end));
                end
            end
            pop <= !chance(receiver_idle_pct());
        end
    end

    // watchdog on cycles with no handshake at all
    int stall_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_wen) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", stall_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus helpers
    function automatic t_point random_point();
        t_point pt;
        pt.x    = $urandom;
        pt.y    = $urandom;
        pt.z    = $urandom;
        pt.last = 1'b0;
        return pt;
    endfunction

    function automatic logic signed [31:0] jitter(input int unsigned spread);
        logic signed [31:0] raw;
        raw = $urandom;
        return raw >>> (32 - spread);
    endfunction

    task automatic add_point(input t_point pt);
        stim_q.push_back('{kind: STEP_POINT, pt: pt, inv: 32'd0});
    endtask

    task automatic add_drain();
        stim_q.push_back('{kind: STEP_DRAIN, pt: '0, inv: 32'd0});
    endtask

    task automatic add_setting(input logic [31:0] inv);
        add_drain();
        stim_q.push_back('{kind: STEP_CONFIG, pt: '0, inv: inv});
    endtask

    // one frame of points whose voxels all share one home slot, so the probe
    // window fills up; expects the reciprocal voxel size to be 1.0
    task automatic add_crowded_frame();
        t_point      members[$];
        t_point      cand;
        t_point      tail;
        int unsigned target;
        bit          fresh;
        cand   = random_point();
        target = home_slot(voxel_key(cand, INV_ONE));
        members.push_back(cand);
        while (members.size() < PROBE_WINDOW + 1) begin
            cand = random_point();
            if (home_slot(voxel_key(cand, INV_ONE)) == target) begin
                fresh = 1'b1;
                foreach (members[i]) begin
                    if (voxel_key(members[i], INV_ONE) == voxel_key(cand, INV_ONE))
                        fresh = 1'b0;
                end
                if (fresh) members.push_back(cand);
            end
        end
        foreach (members[i]) add_point(members[i]);
        // the voxel that did not fit is still not stored, so it overflows again
        add_point(members[PROBE_WINDOW]);
        // a repeat on the last point gives nothing but still clears the set
        tail      = members[0];
        tail.last = 1'b1;
        add_point(tail);
    endtask

    // frames of clustered points with repeats and some scattered ones
    task automatic add_random_frames(input int n_items);
        t_point      frame[$];
        t_point      center;
        t_point      pt;
        int          left;
        int          len;
        int          k;
        int unsigned spread;
        int unsigned pick;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 30);
            if (len > left) len = left;
            spread = $urandom_range(4, 26);
            center = random_point();
            frame.delete();
            for (k = 0; k < len; k++) begin
                pick = $urandom_range(99);
                if (pick < 20 && frame.size() != 0) begin
                    pt = frame[$urandom_range(frame.size() - 1)];
                end else if (pick < 85) begin
                    pt.x = center.x + jitter(spread);
                    pt.y = center.y + jitter(spread);
                    pt.z = center.z + jitter(spread);
                end else begin
                    pt = random_point();
                end
                pt.last = (k == len - 1);
                frame.push_back(pt);
                add_point(pt);
            end
            left -= len;
        end
    endtask

    // stimulus and end of run
    initial begin
        // reset voxel size: same voxel twice, coordinate extremes, negative floor
        add_point('{x: 32'sd0, y: 32'sd0, z: 32'sd0, last: 1'b0});
        add_point('{x: 32'sd0, y: 32'sd0, z: 32'sd0, last: 1'b0});
        add_point('{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000, z: 32'sd1, last: 1'b0});
        add_point('{x: -32'sd1, y: -32'sd1, z: -32'sd1, last: 1'b1});

        // largest reciprocal: indices clamp both ways, repeat on the last point
        add_setting(INV_MAX);
        add_point('{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF, z: 32'sh8000_0000, last: 1'b0});
        add_point('{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000, z: 32'sh7FFF_FFFF, last: 1'b0});
        add_point('{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF, z: 32'sh8000_0000, last: 1'b1});

        // zero reciprocal: every point lands in voxel zero
        add_setting(INV_ZERO);
        add_point(random_point());
        add_point('{x: $urandom, y: $urandom, z: $urandom, last: 1'b1});

        // full probe window
        add_setting(INV_ONE);
        add_crowded_frame();

        // random frames over a range of voxel sizes
        add_random_frames(160);
        add_setting(INV_RESET);
        add_random_frames(80);
        add_drain();
        add_random_frames(80);
        add_setting(INV_MIN);
        add_random_frames(160);
        add_setting(INV_MAX);
        add_random_frames(160);
        add_setting($urandom);
        add_random_frames(160);
        add_setting(INV_TENTH);
        add_random_frames(160);
        add_setting($urandom_range(32'h0000_1000, 32'h0010_0000));
        add_random_frames(160);
        add_drain();

        while (!all_sent) @(posedge clk);
        repeat (20) @(posedge clk);

        while (kept_q.size() != 0) begin
            report_mismatch("kept point never came out");
            void'(kept_q.pop_front());
        end

        $display("Run covered %0d points over %0d voxel-size writes: %0d kept, %0d dropped",
                 n_pushed, n_settings, n_due, n_dropped);
        $display("%0d points kept on a full probe window, %0d kept points checked",
                 n_overflow, n_seen);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/vgdf_pkg.sv
design/vgdf_front.sv
design/vgdf_queue.sv
design/vgdf_back.sv
design/voxel_grid_dedup_filter_core.sv
test/voxel_grid_dedup_filter_core_tb.sv
